@@ src/fnvh_pkg.sv @@
// fnvh_pkg: shared widths, offset basis, prime shift table and carry-save tree shape
// for the fnv-1a 512 stream hash; no dependencies
`default_nettype none

package fnvh_pkg;

  localparam int HASH_W      = 512;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = HASH_W / WORD_W;
  localparam int IDX_W       = $clog2(NUM_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WORDS - 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [HASH_W-1:0] OFFSET_BASIS = {
    64'hB86DB0B1171F4416, 64'hDCA1E50F309990AC,
    64'hAC87D059C9000000, 64'h0000000000000D21,
    64'hE948F68A34C192F6, 64'h2EA79BC942DBE7CE,
    64'h182036415F56E34B, 64'hAC982AAC4AFE9FD9
  };

  // prime 2^344 + 0x157 as set bit positions
  localparam int NUM_SHIFTS = 7;
  localparam int PRIME_SHIFTS [NUM_SHIFTS] = '{0, 1, 2, 4, 6, 8, 344};

  // three operands (sum, carry, low byte) times seven shifts
  localparam int NUM_OPS    = 3;
  localparam int NUM_TERMS  = NUM_OPS * NUM_SHIFTS;

  // 3:2 compressor tree: 21 -> 14 -> 10 -> 7 -> 5 -> 4 -> 3 -> 2
  localparam int CSA_LEVELS = 7;
  localparam int MAX_GROUPS = 7;
  localparam int LEVEL_GROUPS [CSA_LEVELS]   = '{7, 4, 3, 2, 1, 1, 1};
  localparam int LEVEL_COUNT  [CSA_LEVELS+1] = '{21, 14, 10, 7, 5, 4, 3, 2};

  // hash kept in carry-save form: value = sum + carry mod 2^512
  typedef struct packed {
    logic [HASH_W-1:0] sum;
    logic [HASH_W-1:0] carry;
  } hash_pair_t;

endpackage

`default_nettype wire

@@ src/fnvh_if.sv @@
// fnvh_in_if / fnvh_out_if: valid-ready channels for message bytes and digest words
// depends on fnvh_pkg
`default_nettype none

interface fnvh_in_if;
  import fnvh_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface fnvh_out_if;
  import fnvh_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ src/fnvh_front.sv @@
// fnvh_front: absorbs one byte per cycle while the queue has room, into a carry-save
// hash and queues the unresolved hash at message end; depends on fnvh_pkg, fnvh_if
`default_nettype none

module fnvh_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  fnvh_in_if.sink            in_ch,
  output logic               push_valid,
  input  wire logic          push_ready,
  output fnvh_pkg::hash_pair_t push_data
);
  import fnvh_pkg::*;

  logic [HASH_W-1:0] sum_r, carry_r;
  logic [HASH_W-1:0] sum_nxt, carry_nxt;
  logic [BYTE_W:0]   low_sum;
  logic [HASH_W-1:0] ops     [NUM_OPS];
  logic [HASH_W-1:0] terms_a [NUM_TERMS];
  logic [HASH_W-1:0] terms_b [NUM_TERMS];
  logic              in_accept;

  always_comb begin
    // true low byte of sum + carry, its carry goes on at bit 8
    low_sum = {1'b0, sum_r[BYTE_W-1:0]} + {1'b0, carry_r[BYTE_W-1:0]};
    ops[0]  = {sum_r[HASH_W-1:BYTE_W], {BYTE_W{1'b0}}};
    ops[1]  = {carry_r[HASH_W-1:BYTE_W], {BYTE_W{1'b0}}};
    ops[2]  = HASH_W'({low_sum[BYTE_W], low_sum[BYTE_W-1:0] ^ in_ch.data_byte});

    for (int o = 0; o < NUM_OPS; o++) begin
      for (int k = 0; k < NUM_SHIFTS; k++) begin
        terms_a[o*NUM_SHIFTS + k] = ops[o] << PRIME_SHIFTS[k];
      end
    end

    for (int lvl = 0; lvl < CSA_LEVELS; lvl++) begin
      for (int j = 0; j < NUM_TERMS; j++) begin
        terms_b[j] = '0;
      end
      for (int g = 0; g < MAX_GROUPS; g++) begin
        if (g < LEVEL_GROUPS[lvl]) begin
          terms_b[2*g]   = terms_a[3*g] ^ terms_a[3*g+1] ^ terms_a[3*g+2];
          terms_b[2*g+1] = ((terms_a[3*g] & terms_a[3*g+1]) |
                            (terms_a[3*g] & terms_a[3*g+2]) |
                            (terms_a[3*g+1] & terms_a[3*g+2])) << 1;
        end
      end
      // terms left over at this level pass straight down
      for (int j = 0; j < NUM_TERMS; j++) begin
        if (j >= 3*LEVEL_GROUPS[lvl] && j < LEVEL_COUNT[lvl]) begin
          terms_b[j - LEVEL_GROUPS[lvl]] = terms_a[j];
        end
      end
      for (int j = 0; j < NUM_TERMS; j++) begin
        terms_a[j] = terms_b[j];
      end
    end

    if (in_ch.byte_present) begin
      sum_nxt   = terms_a[0];
      carry_nxt = terms_a[1];
    end else begin
      sum_nxt   = sum_r;
      carry_nxt = carry_r;
    end
  end

  assign in_ch.ready     = push_ready;
  assign in_accept       = in_ch.valid & push_ready;
  assign push_valid      = in_ch.valid & in_ch.end_of_message;
  assign push_data.sum   = sum_nxt;
  assign push_data.carry = carry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= OFFSET_BASIS;
      carry_r <= '0;
    end else if (in_accept) begin
      if (in_ch.end_of_message) begin
        sum_r   <= OFFSET_BASIS;
        carry_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        carry_r <= carry_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/fnvh_queue.sv @@
// fnvh_queue: small register fifo of carry-save hashes between front and back
// depends on fnvh_pkg
`default_nettype none

module fnvh_queue #(
  parameter int DEPTH = fnvh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire fnvh_pkg::hash_pair_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output fnvh_pkg::hash_pair_t pop_data
);
  import fnvh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hash_pair_t       entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/fnvh_back.sv @@
// fnvh_back: resolves a carry-save hash one 64-bit limb per cycle, then streams
// the digest out most significant word first; depends on fnvh_pkg, fnvh_if
`default_nettype none

module fnvh_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire fnvh_pkg::hash_pair_t pop_data,
  fnvh_out_if.source           out_ch
);
  import fnvh_pkg::*;

  typedef enum logic [1:0] {RES_IDLE, RES_SUM, RES_HOLD} res_state_t;

  res_state_t        res_state_r;
  logic [HASH_W-1:0] sum_sh_r, carry_sh_r, acc_r, emit_r;
  logic              cin_r;
  logic [IDX_W-1:0]  cnt_r, idx_r;
  logic              emit_valid_r;
  logic [WORD_W:0]   limb_sum;
  logic              out_accept, emit_free;

  assign limb_sum   = {1'b0, sum_sh_r[WORD_W-1:0]} + {1'b0, carry_sh_r[WORD_W-1:0]}
                      + (WORD_W+1)'(cin_r);
  assign pop_ready  = (res_state_r == RES_IDLE);
  assign out_accept = emit_valid_r & out_ch.ready;
  // output bank can take a new digest this cycle
  assign emit_free  = !emit_valid_r || (out_accept && idx_r == IDX_LAST);

  assign out_ch.valid       = emit_valid_r;
  assign out_ch.digest_word = emit_r[HASH_W-1 -: WORD_W];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_state_r  <= RES_IDLE;
      emit_valid_r <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      cin_r        <= 1'b0;
    end else begin
      unique case (res_state_r)
        RES_IDLE: begin
          if (pop_valid) begin
            sum_sh_r    <= pop_data.sum;
            carry_sh_r  <= pop_data.carry;
            cnt_r       <= '0;
            cin_r       <= 1'b0;
            res_state_r <= RES_SUM;
          end
        end
        RES_SUM: begin
          // ripple carry limb by limb, least significant first
          sum_sh_r   <= sum_sh_r >> WORD_W;
          carry_sh_r <= carry_sh_r >> WORD_W;
          acc_r      <= {limb_sum[WORD_W-1:0], acc_r[HASH_W-1:WORD_W]};
          cin_r      <= limb_sum[WORD_W];
          cnt_r      <= cnt_r + 1'b1;
          if (cnt_r == IDX_LAST) begin
            res_state_r <= RES_HOLD;
          end
        end
        RES_HOLD: begin
          if (emit_free) begin
            res_state_r <= RES_IDLE;
          end
        end
      endcase

      if (res_state_r == RES_HOLD && emit_free) begin
        emit_r       <= acc_r;
        emit_valid_r <= 1'b1;
        idx_r        <= '0;
      end else if (out_accept) begin
        emit_r <= emit_r << WORD_W;
        idx_r  <= idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          emit_valid_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/fnv1a_512_stream_hash.sv @@
// FNV-1a 512-bit stream hash. The input channel takes one message byte per cycle
// while the queue has room: the front keeps the hash in carry-save form, so the
// xor and the multiply by the prime (shifts by 0,1,2,4,6,8 and 344) reduce
// through a combinational 3:2 compressor tree. An end-of-message word queues the
// unresolved hash (two entries by default) and reloads the offset basis into the
// hash registers, so the next message can follow straight on while the queue has
// room. The back part adds the two halves one 64-bit limb per cycle while it
// streams the previous digest, then sends eight 64-bit words, most significant
// first. Digest spacing is set by the back's pop state, limb-by-limb resolve and
// hand-off state, so the result port idles between digests; input stalls only
// when the queue is full.
// Depends on fnvh_pkg, fnvh_if, fnvh_front, fnvh_queue, fnvh_back.
`default_nettype none

module fnv1a_512_stream_hash #(
  parameter int QUEUE_DEPTH = fnvh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fnvh_in_if.sink   in_ch,
  fnvh_out_if.source out_ch
);
  import fnvh_pkg::*;

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  hash_pair_t push_data, pop_data;

  fnvh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fnvh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fnvh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
